FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the floating-point block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/f32asm_pkg.sv
// ----------------------------------------------------------------------------
// f32asm_pkg
// Shared types and constants for the float32 add, subtract and multiply block.
// ----------------------------------------------------------------------------
package f32asm_pkg;

	localparam int CmdW  = 2;
	localparam int WordW = 32;
	localparam int ExpW  = 8;
	localparam int FracW = 23;
	localparam int SigW  = 24;

	localparam logic [CmdW-1:0] CMD_ADD  = 2'd0;
	localparam logic [CmdW-1:0] CMD_SUB  = 2'd1;
	localparam logic [CmdW-1:0] CMD_MUL  = 2'd2;
	// The unused opcode is decoded by its upper bit and behaves as multiply.
	localparam logic [CmdW-1:0] CMD_RSVD = 2'd3;

	localparam logic [ExpW-1:0] EXP_BIAS = 8'd127;

	typedef struct packed {
		logic [CmdW-1:0]  cmd;
		logic [WordW-1:0] lhs_bits;
		logic [WordW-1:0] rhs_bits;
	} op_t;

endpackage

FILE: rtl/float32_add_sub_mul.sv
// ----------------------------------------------------------------------------
// float32_add_sub_mul
// Truncating single-precision add, subtract and multiply, one op per cycle unless m_axis stalls.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents (tdata, low bits first)
// s_axis   in   cmd[1:0], lhs_bits[33:2], rhs_bits[65:34], zero fill to 72
// m_axis   out  result_bits[31:0]
//
// An operation is registered on entry and its result in the output register;
// one beat per cycle is sustained while m_axis_tready stays high.
// The input and output registers form a two-stage pipeline that advances when
// the result register is empty or being drained. Reset empties both stages.
module float32_add_sub_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // cmd, lhs_bits, rhs_bits, zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // result_bits
);

	f32asm_pkg::op_t  op_s1;
	logic             vld_s1, vld_s2;
	logic [31:0]      res_s2, as_res, mul_res;
	logic             adv2, adv1;

	assign adv2 = !vld_s2 || m_axis_tready;
	assign adv1 = !vld_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= s_axis_tvalid;
			if (adv2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			op_s1 <= {s_axis_tdata[1:0], s_axis_tdata[33:2], s_axis_tdata[65:34]};
		end
		if (adv2 && vld_s1) begin
			res_s2 <= op_s1.cmd[1] ? mul_res : as_res;
		end
	end

	f32asm_addsub u_addsub (
		.lhs_bits    (op_s1.lhs_bits),
		.rhs_bits    (op_s1.rhs_bits),
		.negate      (op_s1.cmd == f32asm_pkg::CMD_SUB),
		.result_bits (as_res)
	);

	f32asm_mul u_mul (
		.lhs_bits    (op_s1.lhs_bits),
		.rhs_bits    (op_s1.rhs_bits),
		.result_bits (mul_res)
	);

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = res_s2;

`include "assert_macros.svh"

	`ASSERT_NEXT(a_hold_out, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_IMPL(a_ready_free, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`ASSERT_NEXT(a_s1_moves, clk, arst_n, vld_s1 && adv2, m_axis_tvalid)

endmodule

FILE: rtl/f32asm_addsub.sv
// ----------------------------------------------------------------------------
// f32asm_addsub
// Aligns, adds and normalizes two single-precision patterns (truncating).
// ----------------------------------------------------------------------------
module f32asm_addsub (
	input  logic [f32asm_pkg::WordW-1:0] lhs_bits,
	input  logic [f32asm_pkg::WordW-1:0] rhs_bits,
	input  logic                         negate,
	output logic [f32asm_pkg::WordW-1:0] result_bits
);

	logic                              sa, sb, sgn;
	logic [f32asm_pkg::ExpW-1:0]       ea, eb, e_big, diff, e_out;
	logic [f32asm_pkg::SigW-1:0]       fa, fb, f_big, f_small, f_al, mag24;
	logic                              swap;
	logic [f32asm_pkg::SigW+1:0]       va, vb, sum;
	logic [f32asm_pkg::SigW:0]         mag;
	logic [4:0]                        lz;
	logic                              found;

	always_comb begin
		sa = lhs_bits[31];
		sb = rhs_bits[31] ^ negate;
		ea = lhs_bits[30:23];
		eb = rhs_bits[30:23];
		fa = {1'b1, lhs_bits[22:0]};
		fb = {1'b1, rhs_bits[22:0]};
		swap = ea < eb;
		diff = swap ? (eb - ea) : (ea - eb);
		e_big = swap ? eb : ea;
		f_big = swap ? fb : fa;
		f_small = swap ? fa : fb;
		f_al = (diff >= 8'd24) ? '0 : (f_small >> diff[4:0]);
		// Operands in two's complement with room for the sign and the carry.
		va = {2'b00, swap ? f_al : f_big};
		vb = {2'b00, swap ? f_big : f_al};
		if (sa) va = -va;
		if (sb) vb = -vb;
		sum = va + vb;
		sgn = sum[25];
		mag = sgn ? 25'(-sum) : sum[24:0];
		e_out = e_big;
		if (mag[24]) begin
			mag24 = mag[24:1];
			e_out = e_big + 8'd1;
		end else begin
			mag24 = mag[23:0];
		end
		lz = '0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && mag24[i]) begin
				found = 1'b1;
				lz = 5'(23 - i);
			end
		end
		mag24 = mag24 << lz;
		e_out = e_out - {3'b000, lz};
		if (mag == '0) result_bits = '0;
		else result_bits = {sgn, e_out, mag24[22:0]};
	end

endmodule

FILE: rtl/f32asm_mul.sv
// ----------------------------------------------------------------------------
// f32asm_mul
// Multiplies two single-precision patterns with a truncated product.
// ----------------------------------------------------------------------------
module f32asm_mul (
	input  logic [f32asm_pkg::WordW-1:0] lhs_bits,
	input  logic [f32asm_pkg::WordW-1:0] rhs_bits,
	output logic [f32asm_pkg::WordW-1:0] result_bits
);

	logic [47:0]                 prod;
	logic [24:0]                 p;
	logic [f32asm_pkg::ExpW-1:0] e;

	always_comb begin
		prod = {24'd0, 1'b1, lhs_bits[22:0]} * {24'd0, 1'b1, rhs_bits[22:0]};
		p = prod[47:23];
		e = lhs_bits[30:23] + rhs_bits[30:23] - f32asm_pkg::EXP_BIAS;
		if (p[24]) begin
			result_bits = {lhs_bits[31] ^ rhs_bits[31], e + 8'd1, p[23:1]};
		end else begin
			result_bits = {lhs_bits[31] ^ rhs_bits[31], e, p[22:0]};
		end
	end

endmodule
